### rtl/mgpt_pkg.sv
package mgpt_pkg;

  localparam int unsigned TRAIL_DEPTH = 1024;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned ADDR_W      = $clog2(TRAIL_DEPTH);
  localparam int unsigned CNT_W       = ADDR_W + 1;
  localparam int unsigned CLAMP_W     = 15;
  localparam int unsigned THRESH_W    = 33;
  localparam int unsigned SQ_W        = 2 * (SAMPLE_BITS + 1);
  localparam int unsigned D2_W        = SQ_W + 2;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned MASK_W      = 3;
  localparam int unsigned AGE_W       = 10;
  localparam int unsigned ACT_W       = 3;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = THRESH_W;
  localparam int unsigned S_DATA_W    = 64;
  localparam int unsigned S_USER_W    = CMD_W + MASK_W;
  localparam int unsigned M_DATA_W    = 72;
  localparam int unsigned M_USER_W    = ACT_W;

  localparam logic [CLAMP_W-1:0]  CLAMP_RST  = 15'd20480;
  localparam logic [THRESH_W-1:0] THRESH_RST = 33'd41943;

  localparam logic [CFG_IDX_W-1:0] REG_CLAMP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 1'd1;

  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_IGNORED   = 3'd0,
    ACT_APPEND    = 3'd1,
    ACT_OVERWRITE = 3'd2,
    ACT_UPDATE    = 3'd3,
    ACT_CLEARED   = 3'd4,
    ACT_READ_OK   = 3'd5,
    ACT_READ_OOR  = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COND,
    S_MUL,
    S_EXEC,
    S_EMIT
  } state_e;

  // axis 0 = x, 1 = y, 2 = z
  typedef logic [2:0][SAMPLE_BITS-1:0] point_t;

  typedef struct packed {
    logic cond_en;
    logic mul_en;
  } dist_ctl_t;

endpackage

### rtl/mgpt_store.sv
module mgpt_store (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [mgpt_pkg::ADDR_W-1:0] waddr_i,
  input  mgpt_pkg::point_t      wdata_i,
  input  logic                  re_i,
  input  logic [mgpt_pkg::ADDR_W-1:0] raddr_i,
  output mgpt_pkg::point_t      rdata_o
);
  import mgpt_pkg::*;

  point_t mem [TRAIL_DEPTH];
  point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mgpt_dist.sv
module mgpt_dist (
  input  logic                          clk_i,
  input  mgpt_pkg::dist_ctl_t           ctl_i,
  input  mgpt_pkg::point_t              raw_i,
  input  logic [mgpt_pkg::MASK_W-1:0]   bad_mask_i,
  input  logic [mgpt_pkg::CLAMP_W-1:0]  clamp_i,
  input  mgpt_pkg::point_t              last_i,
  output mgpt_pkg::point_t              point_o,
  output logic [mgpt_pkg::D2_W-1:0]     d2_o
);
  import mgpt_pkg::*;

  point_t cond_d, cond_q, pt2_q;
  logic [2:0][SQ_W-1:0] sq_d, sq_q;
  logic signed [SAMPLE_BITS:0] lim, s, diff;
  logic signed [SQ_W-1:0] prod;

  // force flagged axes to zero, then saturate to +/- clamp
  always_comb begin
    lim    = $signed({2'b00, clamp_i});
    cond_d = '0;
    s      = '0;
    for (int a = 0; a < 3; a++) begin
      s = $signed({raw_i[a][SAMPLE_BITS-1], raw_i[a]});
      if (bad_mask_i[a]) begin
        s = '0;
      end
      if (s > lim) begin
        s = lim;
      end
      if (s < -lim) begin
        s = -lim;
      end
      cond_d[a] = s[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    sq_d = '0;
    diff = '0;
    prod = '0;
    for (int a = 0; a < 3; a++) begin
      diff = $signed({cond_q[a][SAMPLE_BITS-1], cond_q[a]})
           - $signed({last_i[a][SAMPLE_BITS-1], last_i[a]});
      prod = SQ_W'(diff) * SQ_W'(diff);
      sq_d[a] = prod;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cond_en) begin
      cond_q <= cond_d;
    end
    if (ctl_i.mul_en) begin
      sq_q  <= sq_d;
      pt2_q <= cond_q;
    end
  end

  assign point_o = pt2_q;
  assign d2_o    = D2_W'(sq_q[0]) + D2_W'(sq_q[1]) + D2_W'(sq_q[2]);

endmodule

### rtl/motion_gated_point_trail.sv
// An accepted transaction steps through the condition, square, execute and
// emit steps, one item at a time around the trail memory; s_tready stays low
// until the result is posted, so no new item is taken before then.
// A result waiting on m_tready stalls only the emit step.
// Reset clears count, oldest slot and last point and loads the config defaults;
// the trail memory is not cleared, entries are valid only once written.
module motion_gated_point_trail (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // x[15:0], y[31:16], z[47:32], read_age[57:48], zero pad
  input  logic [mgpt_pkg::S_DATA_W-1:0]       s_tdata,
  // cmd[1:0], bad_mask[4:2]
  input  logic [mgpt_pkg::S_USER_W-1:0]       s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // point_count[10:0], slot[20:11], read_x[36:21], read_y[52:37],
  // read_z[68:53], zero pad
  output logic [mgpt_pkg::M_DATA_W-1:0]       m_tdata,
  // action[2:0]
  output logic [mgpt_pkg::M_USER_W-1:0]       m_tuser,
  input  logic                                cfg_we_i,
  input  logic [mgpt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mgpt_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import mgpt_pkg::*;

  state_e state_q, state_d;

  logic [CLAMP_W-1:0]  clamp_q;
  logic [THRESH_W-1:0] thresh_q;

  logic [CMD_W-1:0]  in_cmd_q;
  logic [MASK_W-1:0] in_mask_q;
  logic [AGE_W-1:0]  in_age_q;
  point_t            in_pt_q;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] oldest_q, oldest_d;
  point_t            last_q, last_d;

  action_e           act_q, act_d;
  logic [ADDR_W-1:0] slot_q, slot_d;

  logic              m_tvalid_q;
  logic [M_DATA_W-1:0] m_tdata_q;
  logic [M_USER_W-1:0] m_tuser_q;

  logic      accept, exec_en, emit_en;
  dist_ctl_t dist_ctl;
  point_t    cond_pt, rdata;
  logic [D2_W-1:0] d2;
  logic      mem_we, mem_re;
  point_t    rd_pt;

  // ---------------- FSM ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_tvalid) begin
        state_d = S_COND;
      end
      S_COND: state_d = S_MUL;
      S_MUL:  state_d = S_EXEC;
      S_EXEC: state_d = S_EMIT;
      S_EMIT: if (!m_tvalid_q || m_tready) begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready         = (state_q == S_IDLE);
    dist_ctl.cond_en = (state_q == S_COND);
    dist_ctl.mul_en  = (state_q == S_MUL);
    exec_en          = (state_q == S_EXEC);
    emit_en          = (state_q == S_EMIT) && (!m_tvalid_q || m_tready);
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- config ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_q  <= CLAMP_RST;
      thresh_q <= THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CLAMP:  clamp_q  <= cfg_wdata_i[CLAMP_W-1:0];
        REG_THRESH: thresh_q <= cfg_wdata_i[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input capture ----------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_pt_q[0] <= s_tdata[15:0];
      in_pt_q[1] <= s_tdata[31:16];
      in_pt_q[2] <= s_tdata[47:32];
      in_age_q   <= s_tdata[57:48];
      in_cmd_q   <= s_tuser[1:0];
      in_mask_q  <= s_tuser[4:2];
    end
  end

  mgpt_dist u_dist (
    .clk_i      (clk_i),
    .ctl_i      (dist_ctl),
    .raw_i      (in_pt_q),
    .bad_mask_i (in_mask_q),
    .clamp_i    (clamp_q),
    .last_i     (last_q),
    .point_o    (cond_pt),
    .d2_o       (d2)
  );

  // ---------------- execute ----------------
  always_comb begin
    cnt_d    = cnt_q;
    oldest_d = oldest_q;
    last_d   = last_q;
    act_d    = ACT_IGNORED;
    slot_d   = '0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    if (exec_en) begin
      unique case (in_cmd_q)
        CMD_SAMPLE: begin
          if (d2 > D2_W'(thresh_q)) begin
            if (cnt_q != CNT_W'(TRAIL_DEPTH)) begin
              slot_d = oldest_q + cnt_q[ADDR_W-1:0];
              cnt_d  = cnt_q + CNT_W'(1);
              act_d  = ACT_APPEND;
            end else begin
              slot_d   = oldest_q;
              oldest_d = oldest_q + ADDR_W'(1);
              act_d    = ACT_OVERWRITE;
            end
            mem_we = 1'b1;
            last_d = cond_pt;
          end else if (cnt_q != '0) begin
            slot_d = oldest_q + cnt_q[ADDR_W-1:0] - ADDR_W'(1);
            mem_we = 1'b1;
            act_d  = ACT_UPDATE;
          end
        end
        CMD_CLEAR: begin
          cnt_d    = '0;
          oldest_d = '0;
          last_d   = '0;
          act_d    = ACT_CLEARED;
        end
        CMD_READ: begin
          if (CNT_W'(in_age_q) < cnt_q) begin
            slot_d = oldest_q + ADDR_W'(in_age_q);
            mem_re = 1'b1;
            act_d  = ACT_READ_OK;
          end else begin
            act_d  = ACT_READ_OOR;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      oldest_q <= '0;
      last_q   <= '0;
    end else begin
      cnt_q    <= cnt_d;
      oldest_q <= oldest_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_en) begin
      act_q  <= act_d;
      slot_q <= slot_d;
    end
  end

  mgpt_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (slot_d),
    .wdata_i (cond_pt),
    .re_i    (mem_re),
    .raddr_i (slot_d),
    .rdata_o (rdata)
  );

  // ---------------- output register ----------------
  assign rd_pt = (act_q == ACT_READ_OK) ? rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (emit_en) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      m_tdata_q <= {3'b000, rd_pt[2], rd_pt[1], rd_pt[0], slot_q, cnt_q};
      m_tuser_q <= act_q;
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = m_tdata_q;
  assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TRAIL_DEPTH))
    else $error("trail count above depth");

  a_we_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we || mem_re) |-> (state_q == S_EXEC))
    else $error("memory access outside execute step");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_en && in_cmd_q == CMD_CLEAR) |=> (cnt_q == '0 && oldest_q == '0))
    else $error("clear did not empty the trail");

  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (CNT_W'(in_age_q) < cnt_q))
    else $error("read beyond trail");

  a_emit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_en |=> (state_q == S_IDLE && m_tvalid_q))
    else $error("emit did not post a result");
`endif

endmodule
